/* rtl/core/bar_pkg.sv */
package bar_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int ADDR_W        = 64;
  localparam int SLOT_FIELD_W  = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_REMOVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ADD    = 3'd5;

  typedef struct packed {
    logic                    op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    slot_valid;
    logic [ADDR_W-1:0]       region_base;
    logic [ADDR_W-1:0]       region_size;
    logic [ADDR_W-1:0]       region_remove;
    logic [ADDR_W-1:0]       region_add;
    logic [ADDR_W-1:0]       access_addr;
    logic [ADDR_W-1:0]       access_len;
  } in_item_t;

  typedef struct packed {
    logic                    status;
    logic [SLOT_FIELD_W-1:0] target_slot;
    logic                    to_default;
    logic [ADDR_W-1:0]       out_addr;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] remove;
    logic [ADDR_W-1:0] add;
  } slot_entry_t;

  // Shared adder operations: a+b, a-b, a+b-1, and a>=b on the carry
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_DEC,
    ALU_GE
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              ge;
  } alu_res_t;

endpackage

/* rtl/core/bar_alu.sv */
module bar_alu import bar_pkg::*; (
  input  alu_req_t req,
  output alu_res_t res
);

  logic [ADDR_W:0] b_ext;
  logic [ADDR_W:0] c_ext;
  logic [ADDR_W:0] total;

  always_comb begin
    b_ext = {1'b0, req.b};
    c_ext = '0;
    unique case (req.op)
      ALU_ADD: begin
        b_ext = {1'b0, req.b};
      end
      ALU_SUB, ALU_GE: begin
        b_ext = {1'b0, ~req.b};
        c_ext = (ADDR_W+1)'(1);
      end
      ALU_DEC: begin
        c_ext = {1'b0, {ADDR_W{1'b1}}};
      end
    endcase
    total   = {1'b0, req.a} + b_ext + c_ext;
    res.sum = total[ADDR_W-1:0];
    // carry out of a + ~b + 1 is set exactly when a >= b
    res.ge  = total[ADDR_W];
  end

endmodule

/* rtl/core/bus_address_router.sv */
// Address decoder with a table of MAX_SLOTS mapped regions, an optional error
// region and an optional default target. A load word (op 0) writes one table
// slot and gives no result; loads to a slot number at or
// beyond MAX_SLOTS are dropped. A route word (op 1) gives one result word: the
// table is scanned one slot per cycle through a registered read port, keeping
// the valid slot with the greatest base not above the address (lowest slot on
// a tie); the range checks, error-region check and address translation then
// run as a short sequence of steps on one shared 64-bit adder/comparator.
// Each route step uses the adder in turn: access end, region end, base compare
// and end compare, then translation on a hit. On a miss the region checks run
// again on the error region if enabled (a hit there gives an invalid result),
// then the default target translates the address or an invalid result is given.
// The block takes no new word while a route is in progress, but does take the
// next word while a finished result still waits on the output. Configuration
// writes are taken at any time and should be made while the block is idle.
module bus_address_router import bar_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  localparam out_item_t RES_INVALID = '{status: 1'b1, target_slot: '0,
                                        to_default: 1'b0, out_addr: '0};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACC_END,
    ST_REG_END,
    ST_BASE_CMP,
    ST_END_CMP,
    ST_DEFAULT,
    ST_XLATE,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic              error_enable;
  logic [ADDR_W-1:0] error_base;
  logic [ADDR_W-1:0] error_size;
  logic              default_enable;
  logic [ADDR_W-1:0] default_remove;
  logic [ADDR_W-1:0] default_add;

  // slot table
  slot_entry_t       table_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_bits;
  slot_entry_t       rd_entry;
  logic              rd_pend;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  scan_cnt;

  // route working registers
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] len_q;
  logic              found;
  logic [IDX_W-1:0]  pick_idx;
  slot_entry_t       pick_entry;
  logic [ADDR_W-1:0] acc_end;
  logic [ADDR_W-1:0] reg_end;
  logic              base_ok;
  logic              err_phase;
  logic              xl_def;
  out_item_t         res;

  logic              in_acc;
  logic              slot_ok;
  logic              load_we;
  logic              rd_en;
  logic              scan_hit;
  logic              scan_last;
  logic [ADDR_W-1:0] chk_base;
  logic [ADDR_W-1:0] chk_size;
  logic [ADDR_W-1:0] xl_rem;
  logic [ADDR_W-1:0] xl_add;
  alu_req_t          alu_req;
  alu_res_t          alu_res;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_ok   = (int'(in_data.slot) < MAX_SLOTS);
  assign load_we   = in_acc && (in_data.op == OP_LOAD) && slot_ok;
  assign rd_en     = (state == ST_SCAN) && (scan_cnt < CNT_W'(MAX_SLOTS));

  assign scan_hit  = rd_pend && rd_valid && (rd_entry.base <= addr_q) &&
                     (!found || (rd_entry.base > pick_entry.base));
  assign scan_last = rd_pend && (rd_idx == IDX_W'(MAX_SLOTS - 1));

  assign chk_base  = err_phase ? error_base : pick_entry.base;
  assign chk_size  = err_phase ? error_size : pick_entry.size;
  assign xl_rem    = xl_def ? default_remove : pick_entry.remove;
  assign xl_add    = xl_def ? default_add    : pick_entry.add;

  always_ff @(posedge clk) begin
    if (load_we) begin
      table_mem[IDX_W'(in_data.slot)] <= '{base:   in_data.region_base,
                                           size:   in_data.region_size,
                                           remove: in_data.region_remove,
                                           add:    in_data.region_add};
    end
    if (rd_en) begin
      rd_entry <= table_mem[scan_cnt[IDX_W-1:0]];
    end
  end

  always_comb begin
    alu_req = '{op: ALU_ADD, a: addr_q, b: '0};
    unique case (state)
      ST_ACC_END:  alu_req = '{op: ALU_DEC, a: addr_q,   b: len_q};
      ST_REG_END:  alu_req = '{op: ALU_DEC, a: chk_base, b: chk_size};
      ST_BASE_CMP: alu_req = '{op: ALU_GE,  a: addr_q,   b: chk_base};
      ST_END_CMP:  alu_req = '{op: ALU_GE,  a: reg_end,  b: acc_end};
      ST_XLATE: begin
        // a nonzero add offset wins over the remove offset
        if (xl_add != '0) begin
          alu_req = '{op: ALU_ADD, a: addr_q, b: xl_add};
        end else if (xl_rem != '0) begin
          alu_req = '{op: ALU_SUB, a: addr_q, b: xl_rem};
        end else begin
          alu_req = '{op: ALU_ADD, a: addr_q, b: '0};
        end
      end
      default: alu_req = '{op: ALU_ADD, a: addr_q, b: '0};
    endcase
  end

  bar_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      valid_bits     <= '0;
      error_enable   <= 1'b0;
      error_base     <= '0;
      error_size     <= '0;
      default_enable <= 1'b0;
      default_remove <= '0;
      default_add    <= '0;
      found          <= 1'b0;
      rd_pend        <= 1'b0;
      scan_cnt       <= '0;
      err_phase      <= 1'b0;
      xl_def         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ERROR_ENABLE:   error_enable   <= cfg_data[0];
          REG_ERROR_BASE:     error_base     <= cfg_data;
          REG_ERROR_SIZE:     error_size     <= cfg_data;
          REG_DEFAULT_ENABLE: default_enable <= cfg_data[0];
          REG_DEFAULT_REMOVE: default_remove <= cfg_data;
          REG_DEFAULT_ADD:    default_add    <= cfg_data;
          default: ;
        endcase
      end

      // in ST_DONE the output register is reloaded below instead
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.op == OP_LOAD) begin
              if (slot_ok) begin
                valid_bits[IDX_W'(in_data.slot)] <= in_data.slot_valid;
              end
            end else begin
              addr_q    <= in_data.access_addr;
              len_q     <= in_data.access_len;
              found     <= 1'b0;
              scan_cnt  <= '0;
              rd_pend   <= 1'b0;
              err_phase <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            rd_idx   <= scan_cnt[IDX_W-1:0];
            rd_valid <= valid_bits[scan_cnt[IDX_W-1:0]];
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          // strict compare keeps the lowest slot on equal bases
          if (scan_hit) begin
            found      <= 1'b1;
            pick_idx   <= rd_idx;
            pick_entry <= rd_entry;
          end
          if (scan_last) begin
            state <= ST_ACC_END;
          end
        end
        ST_ACC_END: begin
          acc_end <= alu_res.sum;
          if (found) begin
            state <= ST_REG_END;
          end else if (error_enable) begin
            err_phase <= 1'b1;
            state     <= ST_REG_END;
          end else begin
            state <= ST_DEFAULT;
          end
        end
        ST_REG_END: begin
          reg_end <= alu_res.sum;
          state   <= ST_BASE_CMP;
        end
        ST_BASE_CMP: begin
          base_ok <= alu_res.ge;
          state   <= ST_END_CMP;
        end
        ST_END_CMP: begin
          if (base_ok && alu_res.ge) begin
            if (!err_phase) begin
              xl_def <= 1'b0;
              state  <= ST_XLATE;
            end else begin
              res   <= RES_INVALID;
              state <= ST_DONE;
            end
          end else if (!err_phase && error_enable) begin
            err_phase <= 1'b1;
            state     <= ST_REG_END;
          end else begin
            state <= ST_DEFAULT;
          end
        end
        ST_DEFAULT: begin
          if (default_enable) begin
            xl_def <= 1'b1;
            state  <= ST_XLATE;
          end else begin
            res   <= RES_INVALID;
            state <= ST_DONE;
          end
        end
        ST_XLATE: begin
          res.status      <= 1'b0;
          res.target_slot <= xl_def ? '0 : SLOT_FIELD_W'(pick_idx);
          res.to_default  <= xl_def;
          res.out_addr    <= alu_res.sum;
          state           <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_route_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == OP_ROUTE) |=> !in_ready)
    else $error("block took a word while a route was in progress");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      (out_data.target_slot == '0) && !out_data.to_default && (out_data.out_addr == '0))
    else $error("invalid result carries nonzero fields");

  a_default_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.to_default |->
      !out_data.status && (out_data.target_slot == '0))
    else $error("default result with status or slot set");

  a_scan_pick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && scan_hit |=> found && (pick_idx == $past(rd_idx)))
    else $error("scan hit not recorded");

endmodule
